### rtl/spsa_pkg.sv
// ----------------------------------------------------------------------------
// Slab page slot allocator package
// Shared widths, codes, request and response types, and the scan token
// that travels along the row of slot cells.
// ----------------------------------------------------------------------------
package spsa_pkg;

    localparam int MAX_SLOTS  = 64;
    localparam int SLOT_W     = 6;
    localparam int CNT_W      = 7;
    localparam int LOC_W      = 3;
    localparam int CELL_SLOTS = 1 << LOC_W;
    localparam int ID_W       = SLOT_W - LOC_W;
    localparam int NUM_CELLS  = (MAX_SLOTS + CELL_SLOTS - 1) / CELL_SLOTS;
    localparam int BYTES_W    = 21;
    localparam int BASE_W     = 48;
    localparam int ADDR_W     = 64;
    localparam int PROD_W     = SLOT_W + BYTES_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_SLOTS_IN_USE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_BYTES   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAGE_BASE    = 2'd2;

    localparam logic [CNT_W-1:0]   RST_SLOTS_IN_USE = 7'd64;
    localparam logic [BYTES_W-1:0] RST_SLOT_BYTES   = 21'd65536;
    localparam logic [BASE_W-1:0]  RST_PAGE_BASE    = 48'd0;

    typedef struct packed {
        logic              cmd;
        logic [SLOT_W-1:0] slot_sel;
    } req_t;

    typedef struct packed {
        logic              granted;
        logic [ADDR_W-1:0] slot_addr;
        logic [SLOT_W-1:0] slot_taken;
        logic [CNT_W-1:0]  collected;
        logic [CNT_W-1:0]  bad_frees;
    } rsp_t;

    typedef struct packed {
        logic              run;
        logic [CNT_W-1:0]  seen_cnt;
        logic [CNT_W-1:0]  bad_cnt;
        logic              hi_found;
        logic [SLOT_W-1:0] hi_slot;
        logic              lo_found;
        logic [SLOT_W-1:0] lo_slot;
    } tok_t;

    typedef struct packed {
        logic              pend_en;
        logic [SLOT_W-1:0] pend_slot;
        logic              set_en;
        logic [SLOT_W-1:0] set_slot;
        logic [SLOT_W-1:0] start;
        logic [CNT_W-1:0]  count;
    } ctl_t;

endpackage

### rtl/slab_page_slot_allocator_top.sv
// ----------------------------------------------------------------------------
// Slab page slot allocator
// Round-robin bitmap allocator for one page of up to 64 equal slots.
// ----------------------------------------------------------------------------
// A remote free request is accepted and its response is offered in the next
// cycle. For an allocate request, the first slot cell takes the scan token at
// the accepting edge, and the token then walks the remaining seven cells, one
// cell of eight slots per cycle. On the way it collects pending frees and finds
// the first free slot at or after the cursor, else the lowest free slot. The
// chosen slot is then registered, ST_MUL forms slot times slot size and ST_ADD
// adds the page base. One request is in flight at a time, and a new request is
// taken once the response register is empty or being emptied.
// ----------------------------------------------------------------------------
module slab_page_slot_allocator_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  spsa_pkg::req_t                  s_req,
    output logic                            m_valid,
    input  logic                            m_ready,
    output spsa_pkg::rsp_t                  m_rsp,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [spsa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [spsa_pkg::CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_MUL  = 4'b0100,
        ST_ADD  = 4'b1000
    } state_t;

    state_t                         state_reg, state_next;
    logic [spsa_pkg::CNT_W-1:0]     slots_reg;
    logic [spsa_pkg::BYTES_W-1:0]   bytes_reg;
    logic [spsa_pkg::BASE_W-1:0]    base_reg;
    logic [spsa_pkg::SLOT_W-1:0]    cursor_reg, cursor_next;
    logic [spsa_pkg::SLOT_W-1:0]    slot_reg, slot_next;
    logic                           found_reg, found_next;
    logic [spsa_pkg::PROD_W-1:0]    prod_reg, prod_next;
    spsa_pkg::rsp_t                 rsp_reg, rsp_next;
    logic                           m_valid_reg, m_valid_next;

    logic [spsa_pkg::CNT_W-1:0]     count;
    logic [spsa_pkg::SLOT_W-1:0]    start;
    logic                           in_acc;
    logic                           done;
    logic                           found;
    logic [spsa_pkg::SLOT_W-1:0]    chosen;
    logic [spsa_pkg::CNT_W-1:0]     chosen_inc;
    spsa_pkg::tok_t                 head;
    spsa_pkg::tok_t                 tok [spsa_pkg::NUM_CELLS+1];
    spsa_pkg::tok_t                 last;
    spsa_pkg::ctl_t                 ctl;

    assign count = (slots_reg > spsa_pkg::CNT_W'(spsa_pkg::MAX_SLOTS)) ?
                   spsa_pkg::CNT_W'(spsa_pkg::MAX_SLOTS) : slots_reg;
    assign start = ({1'b0, cursor_reg} < count) ? cursor_reg : '0;

    assign s_ready   = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign in_acc    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    always_comb begin
        head     = '0;
        head.run = in_acc && (s_req.cmd == spsa_pkg::CMD_ALLOC);
    end

    assign tok[0] = head;

    assign last       = tok[spsa_pkg::NUM_CELLS];
    assign done       = (state_reg == ST_SCAN) && last.run;
    assign found      = last.hi_found || last.lo_found;
    assign chosen     = last.hi_found ? last.hi_slot : last.lo_slot;
    assign chosen_inc = {1'b0, chosen} + spsa_pkg::CNT_W'(1);

    always_comb begin
        ctl.pend_en   = in_acc && (s_req.cmd == spsa_pkg::CMD_FREE);
        ctl.pend_slot = s_req.slot_sel;
        ctl.set_en    = done && found;
        ctl.set_slot  = chosen;
        ctl.start     = start;
        ctl.count     = count;
    end

    for (genvar g = 0; g < spsa_pkg::NUM_CELLS; g++) begin : g_cell
        spsa_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .cell_id (spsa_pkg::ID_W'(g)),
            .ctl     (ctl),
            .tok_in  (tok[g]),
            .tok_out (tok[g+1])
        );
    end

    always_comb begin
        state_next   = state_reg;
        cursor_next  = cursor_reg;
        slot_next    = slot_reg;
        found_next   = found_reg;
        prod_next    = prod_reg;
        rsp_next     = rsp_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    if (s_req.cmd == spsa_pkg::CMD_FREE) begin
                        rsp_next         = '0;
                        rsp_next.granted = 1'b1;
                        m_valid_next     = 1'b1;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (done) begin
                    found_next          = found;
                    slot_next           = chosen;
                    rsp_next.granted    = found;
                    rsp_next.slot_taken = found ? chosen : '0;
                    rsp_next.collected  = last.seen_cnt;
                    rsp_next.bad_frees  = last.bad_cnt;
                    if (found) begin
                        cursor_next = (chosen_inc < count) ? chosen_inc[spsa_pkg::SLOT_W-1:0] : '0;
                    end
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                prod_next  = spsa_pkg::PROD_W'(slot_reg) * spsa_pkg::PROD_W'(bytes_reg);
                state_next = ST_ADD;
            end
            ST_ADD: begin
                rsp_next.slot_addr = found_reg ?
                    (spsa_pkg::ADDR_W'(base_reg) + spsa_pkg::ADDR_W'(prod_reg)) : '0;
                m_valid_next = 1'b1;
                state_next   = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cursor_reg  <= '0;
            m_valid_reg <= 1'b0;
            slots_reg   <= spsa_pkg::RST_SLOTS_IN_USE;
            bytes_reg   <= spsa_pkg::RST_SLOT_BYTES;
            base_reg    <= spsa_pkg::RST_PAGE_BASE;
        end else begin
            state_reg   <= state_next;
            cursor_reg  <= cursor_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    spsa_pkg::REG_SLOTS_IN_USE: slots_reg <= cfg_data[spsa_pkg::CNT_W-1:0];
                    spsa_pkg::REG_SLOT_BYTES:   bytes_reg <= cfg_data[spsa_pkg::BYTES_W-1:0];
                    spsa_pkg::REG_PAGE_BASE:    base_reg  <= cfg_data[spsa_pkg::BASE_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg  <= slot_next;
        found_reg <= found_next;
        prod_reg  <= prod_next;
        rsp_reg   <= rsp_next;
    end

    assign m_valid = m_valid_reg;
    assign m_rsp   = rsp_reg;

endmodule

### rtl/spsa_cell.sv
// ----------------------------------------------------------------------------
// Slot cell
// Holds the allocated and pending bits of one group of slots. When the scan
// token passes, the cell collects its pending bits, adds its counts and
// records its first free slots, then hands the token to the next cell.
// ----------------------------------------------------------------------------
module spsa_cell (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [spsa_pkg::ID_W-1:0] cell_id,
    input  spsa_pkg::ctl_t            ctl,
    input  spsa_pkg::tok_t            tok_in,
    output spsa_pkg::tok_t            tok_out
);

    logic [spsa_pkg::CELL_SLOTS-1:0] alloc_reg, alloc_next;
    logic [spsa_pkg::CELL_SLOTS-1:0] pend_reg, pend_next;
    spsa_pkg::tok_t                  tok_reg, tok_next;

    logic [spsa_pkg::CELL_SLOTS-1:0] live, upper, seen, bad, clean, free_vec, hi_vec;
    logic [spsa_pkg::CNT_W-1:0]      seen_n, bad_n;
    logic [spsa_pkg::LOC_W-1:0]      hi_loc, lo_loc;
    logic [spsa_pkg::SLOT_W-1:0]     idx;

    always_comb begin
        live   = '0;
        upper  = '0;
        seen_n = '0;
        bad_n  = '0;
        hi_loc = '0;
        lo_loc = '0;
        for (int j = 0; j < spsa_pkg::CELL_SLOTS; j++) begin
            idx      = {cell_id, spsa_pkg::LOC_W'(j)};
            live[j]  = ({1'b0, idx} < ctl.count);
            upper[j] = (idx >= ctl.start);
        end
        seen     = pend_reg & live;
        bad      = seen & ~alloc_reg;
        clean    = alloc_reg & ~seen;
        free_vec = ~clean & live;
        hi_vec   = free_vec & upper;
        for (int j = spsa_pkg::CELL_SLOTS - 1; j >= 0; j--) begin
            seen_n = seen_n + spsa_pkg::CNT_W'(seen[j]);
            bad_n  = bad_n + spsa_pkg::CNT_W'(bad[j]);
            if (hi_vec[j]) begin
                hi_loc = spsa_pkg::LOC_W'(j);
            end
            if (free_vec[j]) begin
                lo_loc = spsa_pkg::LOC_W'(j);
            end
        end
    end

    always_comb begin
        tok_next   = tok_in;
        alloc_next = alloc_reg;
        pend_next  = pend_reg;
        if (tok_in.run) begin
            tok_next.seen_cnt = tok_in.seen_cnt + seen_n;
            tok_next.bad_cnt  = tok_in.bad_cnt + bad_n;
            if (!tok_in.hi_found && (|hi_vec)) begin
                tok_next.hi_found = 1'b1;
                tok_next.hi_slot  = {cell_id, hi_loc};
            end
            if (!tok_in.lo_found && (|free_vec)) begin
                tok_next.lo_found = 1'b1;
                tok_next.lo_slot  = {cell_id, lo_loc};
            end
            alloc_next = clean;
            pend_next  = '0;
        end
        if (ctl.set_en && (ctl.set_slot[spsa_pkg::SLOT_W-1:spsa_pkg::LOC_W] == cell_id)) begin
            alloc_next[ctl.set_slot[spsa_pkg::LOC_W-1:0]] = 1'b1;
        end
        if (ctl.pend_en && (ctl.pend_slot[spsa_pkg::SLOT_W-1:spsa_pkg::LOC_W] == cell_id)) begin
            pend_next[ctl.pend_slot[spsa_pkg::LOC_W-1:0]] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alloc_reg <= '0;
            pend_reg  <= '0;
            tok_reg   <= '0;
        end else begin
            alloc_reg <= alloc_next;
            pend_reg  <= pend_next;
            tok_reg   <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

### bench/tb_slab_page_slot_allocator_top.sv
// ----------------------------------------------------------------------------
// Testbench for the slab page slot allocator
// Drives allocate and remote free requests with random gaps on both sides and
// long output stalls. It reprograms the slot count, the slot size and the
// page base between phases, and checks every response field against a
// bitmap model of the page that is kept alongside the block.
// ----------------------------------------------------------------------------
module tb_slab_page_slot_allocator_top;

    import spsa_pkg::*;

    localparam int RANDOM_ITEMS = 1830;
    localparam int SETTLE_CYCLES = 16;
    localparam int LONG_HOLD = 300;
    localparam int CYCLE_LIMIT = 600000;
    localparam int MAX_PRINTED = 30;

    class slot_ledger;
        logic [CNT_W-1:0]   page_slots = RST_SLOTS_IN_USE;
        logic [BYTES_W-1:0] size_bytes = RST_SLOT_BYTES;
        logic [BASE_W-1:0]  base_addr  = RST_PAGE_BASE;
        logic [MAX_SLOTS-1:0] in_use = '0;
        logic [MAX_SLOTS-1:0] freed_remote = '0;
        int scan_from = 0;
        rsp_t owed_grants[$];
        int errors = 0;
        int checked = 0;
        int grants = 0;
        int misses = 0;
        int frees = 0;

        function int live_count();
            return (page_slots > MAX_SLOTS) ? MAX_SLOTS : int'(page_slots);
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_SLOTS_IN_USE: page_slots = data[CNT_W-1:0];
                REG_SLOT_BYTES: size_bytes = data[BYTES_W-1:0];
                REG_PAGE_BASE: base_addr = data[BASE_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [SLOT_W-1:0] owned_slot();
            int span;
            logic [SLOT_W-1:0] s;
            span = live_count();
            if (span == 0) begin
                span = MAX_SLOTS;
            end
            s = '0;
            for (int k = 0; k < 8; k++) begin
                s = SLOT_W'($urandom_range(0, span - 1));
                if (in_use[s]) begin
                    return s;
                end
            end
            return s;
        endfunction

        function void take_request(req_t r);
            rsp_t e;
            logic [MAX_SLOTS-1:0] lmask, seen, bad;
            int count, start, slot;
            bit found;
            e = '0;
            if (r.cmd == CMD_FREE) begin
                freed_remote[r.slot_sel] = 1'b1;
                e.granted = 1'b1;
                frees++;
            end else begin
                count = live_count();
                lmask = (count >= MAX_SLOTS) ? '1 : ((64'd1 << count) - 64'd1);
                seen = freed_remote & lmask;
                bad = seen & ~in_use;
                in_use = in_use & ~(seen & in_use);
                freed_remote = '0;
                e.collected = CNT_W'($countones(seen));
                e.bad_frees = CNT_W'($countones(bad));
                start = (scan_from >= count) ? 0 : scan_from;
                found = 1'b0;
                for (int n = 0; n < count && !found; n++) begin
                    slot = start + n;
                    if (slot >= count) begin
                        slot -= count;
                    end
                    if (!in_use[slot]) begin
                        found = 1'b1;
                        in_use[slot] = 1'b1;
                        scan_from = (slot + 1 < count) ? slot + 1 : 0;
                        e.granted = 1'b1;
                        e.slot_addr = 64'(base_addr) + 64'(slot) * 64'(size_bytes);
                        e.slot_taken = SLOT_W'(slot);
                    end
                end
                if (found) begin
                    grants++;
                end else begin
                    misses++;
                end
            end
            owed_grants.push_back(e);
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            errors++;
            if (errors <= MAX_PRINTED) begin
                $display("mismatch in %s at response %0d: got %h, expected %h",
                         what, checked, got, want);
            end
        endtask

        task match_response(rsp_t got);
            rsp_t want;
            if (owed_grants.size() == 0) begin
                report("unexpected response", 64'(got.granted), 64'd0);
            end else begin
                want = owed_grants.pop_front();
                if (got.granted !== want.granted)
                    report("granted", 64'(got.granted), 64'(want.granted));
                if (got.slot_addr !== want.slot_addr)
                    report("slot_addr", got.slot_addr, want.slot_addr);
                if (got.slot_taken !== want.slot_taken)
                    report("slot_taken", 64'(got.slot_taken), 64'(want.slot_taken));
                if (got.collected !== want.collected)
                    report("collected", 64'(got.collected), 64'(want.collected));
                if (got.bad_frees !== want.bad_frees)
                    report("bad_frees", 64'(got.bad_frees), 64'(want.bad_frees));
            end
            checked++;
        endtask
    endclass

    logic aclk;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    req_t s_req = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    rsp_t m_rsp;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    slot_ledger ledger = new();
    bit send_quiet = 1'b0;
    bit recv_quiet = 1'b0;
    bit hold_output = 1'b0;
    int reg_writes = 0;
    int cycle_count = 0;

    slab_page_slot_allocator_top dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_req(s_req),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_rsp(m_rsp),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_slab_page_slot_allocator_top: done, errors");
            $finish;
        end
    end

    function automatic int draw_gap(bit quiet);
        return quiet ? 0 : $urandom_range(0, 15);
    endfunction

    task automatic send_request(input logic cmd, input logic [SLOT_W-1:0] sel);
        req_t r;
        int gap;
        r.cmd = cmd;
        r.slot_sel = sel;
        gap = draw_gap(send_quiet);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req <= r;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        ledger.take_request(r);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (cfg_ready !== 1'b1) @(posedge aclk);
        ledger.set_reg(idx, data);
        reg_writes++;
    endtask

    task automatic program_page(input logic [2:0] which, input logic [CNT_W-1:0] count,
                                input logic [BYTES_W-1:0] size,
                                input logic [BASE_W-1:0] base);
        if (which[0]) write_reg(REG_SLOTS_IN_USE, CFG_DATA_W'(count));
        if (which[1]) write_reg(REG_SLOT_BYTES, CFG_DATA_W'(size));
        if (which[2]) write_reg(REG_PAGE_BASE, CFG_DATA_W'(base));
        cfg_valid <= 1'b0;
    endtask

    task automatic settle_page();
        s_valid <= 1'b0;
        while (ledger.owed_grants.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin : result_sink
        int gap;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (hold_output) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_output = 1'b0;
            end
            gap = draw_gap(recv_quiet);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (m_valid !== 1'b1) @(posedge aclk);
            ledger.match_response(m_rsp);
        end
    end

    initial begin : stimulus
        int random_items;
        int burst;
        int phase;
        int pick;
        logic [2:0] which;
        logic [CNT_W-1:0] count;
        logic [BYTES_W-1:0] size;
        logic [BASE_W-1:0] base;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: a repeated free, a free of a slot never handed out.
        send_request(CMD_ALLOC, 6'h3F);
        send_request(CMD_FREE, 6'd0);
        send_request(CMD_FREE, 6'd5);
        send_request(CMD_FREE, 6'd0);
        send_request(CMD_ALLOC, 6'd0);
        send_request(CMD_FREE, 6'd63);
        send_request(CMD_ALLOC, 6'd0);
        settle_page();

        // An empty page misses every allocation and drops pending frees.
        program_page(3'b001, 7'd0, '0, '0);
        send_request(CMD_FREE, 6'd3);
        send_request(CMD_ALLOC, 6'd0);
        send_request(CMD_ALLOC, 6'd0);
        settle_page();

        program_page(3'b111, 7'd100, '1, '1);
        send_request(CMD_FREE, 6'd1);
        send_request(CMD_ALLOC, 6'd0);
        send_request(CMD_ALLOC, 6'd0);
        settle_page();

        // Shrunk page: cursor past the end, a pending free above the count.
        program_page(3'b111, 7'd2, 21'd0, 48'd0);
        send_request(CMD_ALLOC, 6'd0);
        send_request(CMD_ALLOC, 6'd0);
        send_request(CMD_FREE, 6'd1);
        send_request(CMD_FREE, 6'd50);
        send_request(CMD_ALLOC, 6'd0);
        settle_page();

        program_page(3'b011, 7'd1, 21'd1, '0);
        send_request(CMD_ALLOC, 6'd0);
        send_request(CMD_FREE, 6'd0);
        send_request(CMD_ALLOC, 6'd0);
        settle_page();

        program_page(3'b011, 7'd127, 21'd1048576, '0);
        send_request(CMD_ALLOC, 6'd0);
        send_request(CMD_ALLOC, 6'd0);
        settle_page();

        random_items = 0;
        phase = 0;
        while (random_items < RANDOM_ITEMS) begin
            if (phase == 0 || $urandom_range(0, 1) == 1) begin
                which = 3'($urandom_range(1, 7));
                case ($urandom_range(0, 9))
                    0: count = 7'd0;
                    1: count = 7'd64;
                    2: count = 7'($urandom_range(65, 127));
                    3, 4, 5: count = 7'($urandom_range(1, 8));
                    default: count = 7'($urandom_range(1, 64));
                endcase
                case ($urandom_range(0, 5))
                    0: size = 21'd0;
                    1: size = 21'd1;
                    2: size = '1;
                    3: size = 21'd1048576;
                    default: size = 21'($urandom);
                endcase
                case ($urandom_range(0, 3))
                    0: base = '0;
                    1: base = '1;
                    default: base = 48'({$urandom, $urandom});
                endcase
                program_page(which, count, size, base);
            end
            send_quiet = ($urandom_range(0, 3) == 0);
            recv_quiet = ($urandom_range(0, 3) == 0);
            if (phase == 0 || $urandom_range(0, 7) == 0) begin
                hold_output = 1'b1;
            end
            burst = $urandom_range(40, 110);
            if (burst > RANDOM_ITEMS - random_items) begin
                burst = RANDOM_ITEMS - random_items;
            end
            repeat (burst) begin
                pick = $urandom_range(0, 99);
                if (pick < 50) begin
                    send_request(CMD_ALLOC, 6'($urandom));
                end else if (pick < 85) begin
                    send_request(CMD_FREE, ledger.owned_slot());
                end else begin
                    send_request(CMD_FREE, 6'($urandom));
                end
                random_items++;
            end
            settle_page();
            phase++;
        end

        if (ledger.owed_grants.size() != 0) begin
            ledger.report("responses still owed", 64'(ledger.owed_grants.size()), 64'd0);
        end
        $display("covered %0d requests in %0d random phases: %0d grants, %0d misses,",
                 ledger.checked, phase, ledger.grants, ledger.misses);
        $display("%0d remote frees and %0d register writes, %0d cycles",
                 ledger.frees, reg_writes, cycle_count);
        if (ledger.errors == 0) begin
            $display("tb_slab_page_slot_allocator_top: done, clean");
        end else begin
            $display("tb_slab_page_slot_allocator_top: done, errors");
        end
        $finish;
    end

endmodule
